### hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// Greedy box NMS package
// Shared widths, defaults and the kept-entry layout for the NMS block.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int MAX_KEPT_DEFAULT = 64;

    localparam int COORD_W = 13;
    localparam int SIZE_W  = 12;
    localparam int AREA_W  = 24;
    localparam int THR_W   = 17;
    localparam int IDX_W   = 16;
    localparam int SLOT_W  = 6;
    localparam int FRAC_W  = 16;

    localparam logic [THR_W-1:0] THR_RESET = 17'd26214;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [SIZE_W-1:0]  w;
        logic        [SIZE_W-1:0]  h;
        logic        [AREA_W-1:0]  area;
    } kept_entry_t;

    localparam int ENTRY_W = $bits(kept_entry_t);

endpackage

### hw/rtl/greedy_box_nms.sv
// ----------------------------------------------------------------------------
// Greedy box NMS
// Suppresses boxes, given in descending score order, whose IoU with a kept
// box of the same frame is above a programmable Q1.16 threshold.
// ----------------------------------------------------------------------------
// Usage: boxes enter on the in_valid/in_ready channel, one word per box, and
// one result word per box leaves on the out_valid/out_ready channel. The
// user must write the threshold through cfg_wr_en/cfg_wr_data while the
// block is idle; the block does not enforce this. A word with frame_start set
// empties the kept store and restarts the index. Each box reads the kept-entry
// memory once per stored box, one entry per cycle, through a five-stage
// overlap and compare pipeline. A new box is accepted the cycle after the
// previous result is registered, so no box is taken while one is scanned.
// The result sits in an output register, so the next box is accepted and
// scanned while a result still waits. If the receiver stalls, the block holds
// the finished decision until the output register is free.
// Reset empties the store, clears the frame index and loads the default
// threshold of 0.4. Memory contents are not cleared; entries at or above the
// fill count are never used.
// ----------------------------------------------------------------------------
module greedy_box_nms #(
    parameter int MAX_KEPT = gbn_pkg::MAX_KEPT_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [gbn_pkg::THR_W-1:0]         cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              frame_start,
    input  logic signed [gbn_pkg::COORD_W-1:0] box_x,
    input  logic signed [gbn_pkg::COORD_W-1:0] box_y,
    input  logic [gbn_pkg::SIZE_W-1:0]        box_w,
    input  logic [gbn_pkg::SIZE_W-1:0]        box_h,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              keep,
    output logic [gbn_pkg::IDX_W-1:0]         proposal_index,
    output logic [gbn_pkg::SLOT_W-1:0]        kept_slot,
    output logic                              store_full
);
    import gbn_pkg::*;

    localparam int AW   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW   = $clog2(MAX_KEPT + 1);
    localparam int PW   = THR_W + AREA_W + 1;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_KEPT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    state_t                     state_reg;
    logic [THR_W-1:0]           thr_reg;
    logic [CW-1:0]              count_reg;
    logic [IDX_W-1:0]           box_cnt_reg;
    logic [CW-1:0]              iss_reg;

    logic signed [COORD_W-1:0]  cur_x_reg;
    logic signed [COORD_W-1:0]  cur_y_reg;
    logic [SIZE_W-1:0]          cur_w_reg;
    logic [SIZE_W-1:0]          cur_h_reg;
    logic [AREA_W-1:0]          cur_area_reg;
    logic [IDX_W-1:0]           cur_idx_reg;

    kept_entry_t                mem [MAX_KEPT];
    kept_entry_t                rd_data_reg;
    logic                       rd_vld_reg;

    logic                       va_reg;
    logic [SIZE_W-1:0]          ovx_reg;
    logic [SIZE_W-1:0]          ovy_reg;
    logic [AREA_W-1:0]          ka_a_reg;

    logic                       vb_reg;
    logic [AREA_W-1:0]          inter_b_reg;
    logic [AREA_W-1:0]          ka_b_reg;

    logic                       vc_reg;
    logic [AREA_W-1:0]          inter_c_reg;
    logic [AREA_W:0]            uni_reg;

    logic                       vd_reg;
    logic [AREA_W-1:0]          inter_d_reg;
    logic [PW-1:0]              prod_reg;

    logic                       sup_reg;

    logic                       out_valid_reg;
    logic                       keep_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [SLOT_W-1:0]          slot_reg;
    logic                       full_reg;

    logic                       in_fire;
    logic                       issue;
    logic                       pipe_busy;
    logic                       out_free;
    logic                       keep_next;
    logic                       full_next;
    logic                       mem_we;
    logic [AW-1:0]              rd_addr;
    logic [CW+SLOT_W-1:0]       cnt_ext;
    logic [IDX_W-1:0]           idx_next;
    kept_entry_t                wr_entry;

    logic signed [COORD_W:0]    cur_r;
    logic signed [COORD_W:0]    cur_b;
    logic signed [COORD_W:0]    k_r;
    logic signed [COORD_W:0]    k_b;
    logic signed [COORD_W-1:0]  lo_x;
    logic signed [COORD_W-1:0]  lo_y;
    logic signed [COORD_W:0]    hi_x;
    logic signed [COORD_W:0]    hi_y;
    logic signed [COORD_W+1:0]  dx;
    logic signed [COORD_W+1:0]  dy;
    logic [SIZE_W-1:0]          ovx_next;
    logic [SIZE_W-1:0]          ovy_next;

    assign in_ready       = (state_reg == ST_IDLE);
    assign in_fire        = in_valid && in_ready;
    assign out_valid      = out_valid_reg;
    assign keep           = keep_reg;
    assign proposal_index = idx_reg;
    assign kept_slot      = slot_reg;
    assign store_full     = full_reg;

    assign issue     = (state_reg == ST_SCAN) && (iss_reg < count_reg);
    assign rd_addr   = iss_reg[AW-1:0];
    assign pipe_busy = issue || rd_vld_reg || va_reg || vb_reg || vc_reg || vd_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign keep_next = !sup_reg;
    assign full_next = keep_next && (count_reg == COUNT_MAX);
    assign mem_we    = (state_reg == ST_DECIDE) && out_free && keep_next && !full_next;
    assign cnt_ext   = {{SLOT_W{1'b0}}, count_reg};
    assign idx_next  = frame_start ? '0 : box_cnt_reg;

    always_comb
    begin
        wr_entry.x    = cur_x_reg;
        wr_entry.y    = cur_y_reg;
        wr_entry.w    = cur_w_reg;
        wr_entry.h    = cur_h_reg;
        wr_entry.area = cur_area_reg;
    end

    // Overlap extents of the current box against the entry just read.
    always_comb
    begin
        cur_r = (COORD_W+1)'(cur_x_reg) + $signed({2'b00, cur_w_reg});
        cur_b = (COORD_W+1)'(cur_y_reg) + $signed({2'b00, cur_h_reg});
        k_r   = (COORD_W+1)'(rd_data_reg.x) + $signed({2'b00, rd_data_reg.w});
        k_b   = (COORD_W+1)'(rd_data_reg.y) + $signed({2'b00, rd_data_reg.h});
        lo_x  = (cur_x_reg > rd_data_reg.x) ? cur_x_reg : rd_data_reg.x;
        lo_y  = (cur_y_reg > rd_data_reg.y) ? cur_y_reg : rd_data_reg.y;
        hi_x  = (cur_r < k_r) ? cur_r : k_r;
        hi_y  = (cur_b < k_b) ? cur_b : k_b;
        dx    = (COORD_W+2)'(hi_x) - (COORD_W+2)'(lo_x);
        dy    = (COORD_W+2)'(hi_y) - (COORD_W+2)'(lo_y);
        ovx_next = (dx > 0) ? dx[SIZE_W-1:0] : '0;
        ovy_next = (dy > 0) ? dy[SIZE_W-1:0] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[count_reg[AW-1:0]] <= wr_entry;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        ovx_reg     <= ovx_next;
        ovy_reg     <= ovy_next;
        ka_a_reg    <= rd_data_reg.area;
        inter_b_reg <= AREA_W'(ovx_reg) * AREA_W'(ovy_reg);
        ka_b_reg    <= ka_a_reg;
        inter_c_reg <= inter_b_reg;
        uni_reg     <= {1'b0, cur_area_reg} + {1'b0, ka_b_reg} - {1'b0, inter_b_reg};
        inter_d_reg <= inter_c_reg;
        prod_reg    <= PW'(thr_reg) * PW'(uni_reg);
        if (in_fire)
        begin
            cur_x_reg    <= box_x;
            cur_y_reg    <= box_y;
            cur_w_reg    <= box_w;
            cur_h_reg    <= box_h;
            cur_area_reg <= AREA_W'(box_w) * AREA_W'(box_h);
            cur_idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            thr_reg       <= THR_RESET;
            count_reg     <= '0;
            box_cnt_reg   <= '0;
            iss_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            vd_reg        <= 1'b0;
            sup_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            keep_reg      <= 1'b0;
            idx_reg       <= '0;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end

            if (out_valid_reg && out_ready && (state_reg != ST_DECIDE))
            begin
                out_valid_reg <= 1'b0;
            end

            rd_vld_reg <= issue;
            va_reg     <= rd_vld_reg;
            vb_reg     <= va_reg;
            vc_reg     <= vb_reg;
            vd_reg     <= vc_reg;

            if (vd_reg && ({inter_d_reg, {FRAC_W{1'b0}}} > (AREA_W+FRAC_W)'(prod_reg))
                && (prod_reg[PW-1:AREA_W+FRAC_W] == '0))
            begin
                sup_reg <= 1'b1;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        box_cnt_reg <= idx_next + 1'b1;
                        iss_reg     <= '0;
                        sup_reg     <= 1'b0;
                        if (frame_start)
                        begin
                            count_reg <= '0;
                        end
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        iss_reg <= iss_reg + 1'b1;
                    end
                    if (!pipe_busy)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        keep_reg      <= keep_next;
                        idx_reg       <= cur_idx_reg;
                        full_reg      <= full_next;
                        slot_reg      <= (keep_next && !full_next) ? cnt_ext[SLOT_W-1:0] : '0;
                        if (keep_next && !full_next)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/tb_greedy_box_nms.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Greedy box NMS testbench
// Streams boxes into the NMS block in frames and checks every result word
// against a cycle-free model of greedy IoU suppression kept in the bench.
// A short directed part covers the field extremes, disjoint and touching
// boxes, zero-area boxes and threshold crossings. It is followed by random
// frames of clustered boxes, frames that overflow the kept store and noise
// words, run under several thresholds with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_greedy_box_nms;
    import gbn_pkg::*;

    localparam int MAX_KEPT     = MAX_KEPT_DEFAULT;
    localparam int RANDOM_BOXES = 2000;
    localparam int PHASE_BOXES  = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 10;

    typedef enum int {FRAME_CLUSTER, FRAME_FILL, FRAME_NOISE} frame_style_t;

    typedef struct {
        logic                      fs;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [SIZE_W-1:0]  w;
        logic        [SIZE_W-1:0]  h;
    } box_word_t;

    typedef struct {
        logic              keep;
        logic [IDX_W-1:0]  idx;
        logic [SLOT_W-1:0] slot;
        logic              full;
    } nms_result_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [THR_W-1:0]          cfg_wr_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic                      frame_start = 1'b0;
    logic signed [COORD_W-1:0] box_x = '0;
    logic signed [COORD_W-1:0] box_y = '0;
    logic [SIZE_W-1:0]         box_w = '0;
    logic [SIZE_W-1:0]         box_h = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      keep;
    logic [IDX_W-1:0]          proposal_index;
    logic [SLOT_W-1:0]         kept_slot;
    logic                      store_full;

    // Model state of the kept store and the frame index.
    logic [THR_W-1:0] nms_thr = THR_RESET;
    int               kept_x[MAX_KEPT];
    int               kept_y[MAX_KEPT];
    int               kept_w[MAX_KEPT];
    int               kept_h[MAX_KEPT];
    longint           kept_area[MAX_KEPT];
    int               kept_total = 0;
    logic [IDX_W-1:0] frame_pos = '0;

    box_word_t   boxes_to_send[$];
    nms_result_t decisions_due[$];
    box_word_t   cur_box;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit recv_hold = 1'b0;

    int error_count = 0;
    int boxes_accepted = 0;
    int decisions_checked = 0;
    int kept_seen = 0;
    int full_seen = 0;
    int frames_queued = 0;
    int random_queued = 0;
    int thr_settings = 0;

    greedy_box_nms #(
        .MAX_KEPT(MAX_KEPT)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .frame_start(frame_start),
        .box_x(box_x),
        .box_y(box_y),
        .box_w(box_w),
        .box_h(box_h),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .keep(keep),
        .proposal_index(proposal_index),
        .kept_slot(kept_slot),
        .store_full(store_full)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic nms_result_t nms_decide(box_word_t b);
        nms_result_t r;
        int     bx, by, bw, bh, lx, ly, hx, hy, i;
        longint area, inter, uni;
        r.keep = 1'b1;
        r.full = 1'b0;
        r.slot = '0;
        if (b.fs)
        begin
            kept_total = 0;
            frame_pos  = '0;
        end
        bx = b.x;
        by = b.y;
        bw = b.w;
        bh = b.h;
        area = longint'(bw) * longint'(bh);
        r.idx = frame_pos;
        frame_pos = frame_pos + 1'b1;
        for (i = 0; i < kept_total; i++)
        begin
            lx = (bx > kept_x[i]) ? bx : kept_x[i];
            ly = (by > kept_y[i]) ? by : kept_y[i];
            hx = (bx + bw < kept_x[i] + kept_w[i]) ? bx + bw : kept_x[i] + kept_w[i];
            hy = (by + bh < kept_y[i] + kept_h[i]) ? by + bh : kept_y[i] + kept_h[i];
            inter = (hx <= lx || hy <= ly) ? 0 : longint'(hx - lx) * longint'(hy - ly);
            uni = area + kept_area[i] - inter;
            if (inter * 65536 > longint'(nms_thr) * uni)
                r.keep = 1'b0;
        end
        if (r.keep)
        begin
            if (kept_total >= MAX_KEPT)
                r.full = 1'b1;
            else
            begin
                r.slot = kept_total[SLOT_W-1:0];
                kept_x[kept_total]    = bx;
                kept_y[kept_total]    = by;
                kept_w[kept_total]    = bw;
                kept_h[kept_total]    = bh;
                kept_area[kept_total] = area;
                kept_total++;
            end
        end
        return r;
    endfunction

    function automatic box_word_t make_box(bit fs, int x, int y, int w, int h);
        box_word_t b;
        if (w < 0) w = 0;
        if (w > 4095) w = 4095;
        if (h < 0) h = 0;
        if (h > 4095) h = 4095;
        b.fs = fs;
        b.x  = x[COORD_W-1:0];
        b.y  = y[COORD_W-1:0];
        b.w  = w[SIZE_W-1:0];
        b.h  = h[SIZE_W-1:0];
        return b;
    endfunction

    function automatic int spread(int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic box_word_t any_box(bit fs);
        return make_box(fs, int'($urandom_range(0, 8191)) - 4096,
                        int'($urandom_range(0, 8191)) - 4096,
                        $urandom_range(0, 4095), $urandom_range(0, 4095));
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] ERROR: %s", $time, msg);
    endfunction

    function automatic void add_box(box_word_t b);
        boxes_to_send.insert(boxes_to_send.size(), b);
    endfunction

    always @(posedge clk)
    begin : drive_boxes
        bit offer_next;
        if (rst_n)
        begin
            offer_next = in_valid;
            if (in_valid && in_ready)
            begin
                decisions_due.insert(decisions_due.size(), nms_decide(cur_box));
                boxes_accepted++;
                offer_next = 1'b0;
            end
            if (!offer_next)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
                    send_gap = $urandom_range(1, 13);
                else if (boxes_to_send.size() != 0)
                begin
                    cur_box = boxes_to_send.pop_front();
                    offer_next = 1'b1;
                    frame_start <= cur_box.fs;
                    box_x       <= cur_box.x;
                    box_y       <= cur_box.y;
                    box_w       <= cur_box.w;
                    box_h       <= cur_box.h;
                end
            end
            in_valid <= offer_next;
        end
    end

    always @(posedge clk)
    begin : check_results
        nms_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (decisions_due.size() == 0)
                    note_error($sformatf("result word with nothing pending: keep=%0d idx=%0d",
                                         keep, proposal_index));
                else
                begin
                    want = decisions_due.pop_front();
                    decisions_checked++;
                    if (keep !== want.keep || proposal_index !== want.idx ||
                        kept_slot !== want.slot || store_full !== want.full)
                        note_error($sformatf({"mismatch: expected keep=%0d idx=%0d slot=%0d ",
                                              "full=%0d, got keep=%0d idx=%0d slot=%0d full=%0d"},
                                             want.keep, want.idx, want.slot, want.full,
                                             keep, proposal_index, kept_slot, store_full));
                    if (want.keep)
                        kept_seen++;
                    if (want.full)
                        full_seen++;
                end
            end
            if (recv_gap > 0)
                recv_gap--;
            else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct)
                recv_gap = $urandom_range(1, 13);
            out_ready <= !recv_hold && recv_gap == 0;
        end
    end

    task automatic wait_idle();
        while (boxes_to_send.size() != 0 || in_valid || decisions_due.size() != 0)
            @(negedge clk);
        repeat (MAX_KEPT + 16) @(negedge clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        nms_thr     <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        thr_settings++;
        @(negedge clk);
    endtask

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 8;
            default: return 25;
        endcase
    endfunction

    task automatic queue_frame(frame_style_t style);
        int        n, nc, c, k, r;
        int        cx[6], cy[6], cw[6], ch[6];
        bit        fs;
        box_word_t b;
        fs = ($urandom_range(0, 9) != 0);
        case (style)
            FRAME_FILL:
            begin
                n = MAX_KEPT + $urandom_range(1, 16);
                for (k = 0; k < n; k++)
                begin
                    if (k == 0 || $urandom_range(0, 7) != 0)
                        b = make_box(k == 0, -4096 + 100 * k, int'($urandom_range(0, 8191)) - 4096,
                                     $urandom_range(0, 99), $urandom_range(0, 4095));
                    else
                        b.fs = 1'b0;
                    add_box(b);
                end
            end
            FRAME_NOISE:
            begin
                n = $urandom_range(1, 20);
                for (k = 0; k < n; k++)
                    add_box(any_box($urandom_range(0, 3) == 0));
            end
            default:
            begin
                n  = $urandom_range(1, 48);
                nc = $urandom_range(1, 6);
                for (c = 0; c < nc; c++)
                begin
                    cw[c] = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4095)
                                                         : $urandom_range(2, 300);
                    ch[c] = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4095)
                                                         : $urandom_range(2, 300);
                    cx[c] = int'($urandom_range(0, 8191)) - 4096;
                    cy[c] = int'($urandom_range(0, 8191)) - 4096;
                end
                for (k = 0; k < n; k++)
                begin
                    r = $urandom_range(0, 19);
                    c = $urandom_range(0, nc - 1);
                    if (r == 0)
                        b = any_box(k == 0 && fs);
                    else if (r == 1)
                        b = make_box(k == 0 && fs, cx[c] + cw[c], cy[c], cw[c], ch[c]);
                    else
                        b = make_box(k == 0 && fs, cx[c] + spread(cw[c] / 4),
                                     cy[c] + spread(ch[c] / 4), cw[c] + spread(cw[c] / 4),
                                     ch[c] + spread(ch[c] / 4));
                    add_box(b);
                end
            end
        endcase
        random_queued += n;
        frames_queued++;
    endtask

    initial
    begin : stimulus
        logic [THR_W-1:0] thr_list[8];
        int               p, target;
        bit               last;
        thr_list = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1, 17'd32768, 17'd65535,
                     17'd0, THR_RESET};
        thr_list[6] = THR_W'($urandom_range(0, 65536));
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed words at the reset threshold.
        add_box(make_box(1, -4096, -4096, 4095, 4095));
        add_box(make_box(0, -4096, -4096, 4095, 4095));
        add_box(make_box(0, 4095, 4095, 4095, 4095));
        add_box(make_box(0, -1, -4096, 100, 100));
        add_box(make_box(1, 0, 0, 0, 0));
        add_box(make_box(0, 0, 0, 0, 0));
        add_box(make_box(0, 0, 0, 4095, 0));
        add_box(make_box(0, 0, 0, 0, 4095));
        add_box(make_box(1, 0, 0, 100, 100));
        add_box(make_box(0, 0, 0, 100, 60));
        add_box(make_box(0, 0, 0, 100, 30));
        add_box(make_box(0, 0, 0, 100, 40));
        add_box(make_box(0, 50, 0, 100, 100));
        add_box(make_box(0, 100, 100, 50, 50));
        add_box(make_box(1, 4095, -4096, 0, 4095));
        add_box(make_box(0, -4096, 4095, 4095, 0));
        add_box(make_box(0, -1, -1, 2, 2));
        add_box(make_box(0, -2, -2, 2, 2));
        add_box(make_box(0, -1, -1, 2, 2));
        wait_idle();

        for (p = 0; random_queued < RANDOM_BOXES; p++)
        begin
            last = (random_queued + PHASE_BOXES >= RANDOM_BOXES);
            write_threshold(thr_list[p % 8]);
            send_idle_pct  = last ? 0 : pick_idle_pct();
            recv_stall_pct = last ? 0 : pick_idle_pct();
            if (p % 3 == 0)
                queue_frame(FRAME_FILL);
            target = random_queued + PHASE_BOXES;
            while (random_queued < target)
                queue_frame(($urandom_range(0, 9) == 0) ? FRAME_NOISE : FRAME_CLUSTER);
            if (p == 2)
            begin
                recv_hold = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                recv_hold = 1'b0;
            end
            wait_idle();
        end

        $display("Sent %0d box words in %0d frames under %0d threshold settings.",
                 boxes_accepted, frames_queued, thr_settings);
        $display("Checked %0d results: %0d kept, %0d suppressed, %0d kept with the store full.",
                 decisions_checked, kept_seen, decisions_checked - kept_seen, full_seen);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #(20_000_000);
        $display("Timeout with %0d results still pending.", decisions_due.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
